// ----- hdl/scp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Types and constants shared by the container parser modules.
// ----------------------------------------------------------------------------
package scp_pkg;

	// register indexes on the write port
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_MAGIC   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_VERSION = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WANTED  = 2'd2;

	// width of the write data, the widest register
	localparam int unsigned REG_DATA_W = 32;

	// parse phases
	typedef enum logic [2:0] {
		PH_FILE_HDR,
		PH_ENTRY_HDR,
		PH_CODE,
		PH_PAD,
		PH_DONE,
		PH_ERROR
	} scp_phase_t;

	// one input item as it sits in the front queue
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} scp_item_t;

	// fields of the wanted entry
	typedef struct packed {
		logic [31:0] inputs;
		logic [31:0] outputs;
		logic [15:0] samplers;
		logic [15:0] extra;
		logic [31:0] code_size;
		logic [31:0] code_offset;
	} scp_found_t;

	// configuration as seen by the parser's header checks
	typedef struct packed {
		logic [31:0] magic;
		logic [31:0] version;
	} scp_hdr_cfg_t;

endpackage

// ----- hdl/scp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_queue
// Two-entry queue with full and empty flags; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module scp_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ----- hdl/scp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_parser
// Back end: walks the container one item a cycle unless a final byte waits
// on a full result queue; builds the result sent out on each file's last byte.
// ----------------------------------------------------------------------------
module scp_parser #(
	parameter int unsigned MAX_ENTRIES = 4096,
	parameter int unsigned OFFSET_BITS = 32,
	parameter int unsigned CNT_W       = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// front queue
	input  logic                 in_valid,
	input  scp_pkg::scp_item_t   in_item,
	output logic                 in_pop,
	// header checks and entry selection
	input  scp_pkg::scp_hdr_cfg_t hdr_cfg,
	input  logic [CNT_W-1:0]     wanted,
	// result queue
	input  logic                 res_full,
	output logic                 res_push,
	output logic                 res_file_valid,
	output logic [CNT_W-1:0]     res_count,
	output logic                 res_found,
	output scp_pkg::scp_found_t  res_data
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
	localparam logic [31:0]      MAX_W32 = 32'(MAX_ENTRIES);

	scp_pkg::scp_phase_t    ph_q, ph_n;
	logic [3:0]             bih_q, bih_n;
	logic [23:0]            gather_q, gather_n;
	logic [CNT_W-1:0]       count_q, count_n;
	logic [CNT_W-1:0]       epos_q, epos_n;
	logic [31:0]            code_left_q, code_left_n;
	logic [1:0]             pad_q, pad_n;
	logic [OFFSET_BITS-1:0] off_q, off_n;
	scp_pkg::scp_found_t    kept_q, kept_n;
	logic                   have_q, have_n;
	logic                   err_q, err_n;

	logic                   fire;
	logic [31:0]            word;
	logic [1:0]             low;
	logic                   match;
	logic [CNT_W-1:0]       epos_inc;
	logic                   do_next;
	logic                   file_ok;
	logic [OFFSET_BITS:0]   off_inc;
	logic [OFFSET_BITS+32:0] off_ext;
	logic [1:0]             pad_of_size;

	// an item moves on unless it would close a file while the result queue is full
	assign fire   = in_valid & (~in_item.last | ~res_full);
	assign in_pop = fire;

	assign word        = {in_item.data, gather_q};
	assign low         = bih_q[1:0];
	assign match       = (wanted < MAX_CNT) && (epos_q == wanted);
	assign epos_inc    = epos_q + CNT_W'(1);
	assign off_inc     = {1'b0, off_q} + {{OFFSET_BITS{1'b0}}, 1'b1};
	assign off_ext     = {32'd0, off_inc};
	assign pad_of_size = 2'd0 - word[1:0];

	// next-state logic for one byte
	always_comb begin
		ph_n        = ph_q;
		bih_n       = bih_q;
		gather_n    = gather_q;
		count_n     = count_q;
		epos_n      = epos_q;
		code_left_n = code_left_q;
		pad_n       = pad_q;
		off_n       = off_q;
		kept_n      = kept_q;
		have_n      = have_q;
		err_n       = err_q;
		do_next     = 1'b0;

		// assemble little-endian words in the two header phases
		if (ph_q == scp_pkg::PH_FILE_HDR || ph_q == scp_pkg::PH_ENTRY_HDR) begin
			case (low)
				2'd0:    gather_n[7:0]   = in_item.data;
				2'd1:    gather_n[15:8]  = in_item.data;
				2'd2:    gather_n[23:16] = in_item.data;
				default: gather_n        = 24'd0;
			endcase
		end

		case (ph_q)
			scp_pkg::PH_FILE_HDR: begin
				bih_n = bih_q + 4'd1;
				case (bih_q)
					4'd3: begin
						if (word != hdr_cfg.magic) begin
							err_n = 1'b1;
							ph_n  = scp_pkg::PH_ERROR;
						end
					end
					4'd7: begin
						if (word != hdr_cfg.version) begin
							err_n = 1'b1;
							ph_n  = scp_pkg::PH_ERROR;
						end
					end
					4'd11: begin
						if (word > MAX_W32) begin
							err_n = 1'b1;
							ph_n  = scp_pkg::PH_ERROR;
						end else begin
							count_n = word[CNT_W-1:0];
							epos_n  = '0;
							bih_n   = 4'd0;
							ph_n    = (word == 32'd0) ? scp_pkg::PH_DONE
							                          : scp_pkg::PH_ENTRY_HDR;
						end
					end
					default: ;
				endcase
			end
			scp_pkg::PH_ENTRY_HDR: begin
				bih_n = bih_q + 4'd1;
				case (bih_q)
					4'd3:  if (match) kept_n.inputs = word;
					4'd7:  if (match) kept_n.outputs = word;
					4'd11: begin
						if (match) begin
							kept_n.samplers = word[15:0];
							kept_n.extra    = word[31:16];
						end
					end
					4'd15: begin
						if (match) begin
							kept_n.code_size   = word;
							kept_n.code_offset = off_ext[31:0];
							have_n             = 1'b1;
						end
						code_left_n = word;
						pad_n       = pad_of_size;
						bih_n       = 4'd0;
						if (word != 32'd0) ph_n = scp_pkg::PH_CODE;
						else do_next = 1'b1;
					end
					default: ;
				endcase
			end
			scp_pkg::PH_CODE: begin
				code_left_n = code_left_q - 32'd1;
				if (code_left_q == 32'd1) begin
					if (pad_q != 2'd0) ph_n = scp_pkg::PH_PAD;
					else do_next = 1'b1;
				end
			end
			scp_pkg::PH_PAD: begin
				pad_n = pad_q - 2'd1;
				if (pad_q == 2'd1) do_next = 1'b1;
			end
			scp_pkg::PH_DONE: begin
				// trailing byte after the last entry
				err_n = 1'b1;
				ph_n  = scp_pkg::PH_ERROR;
			end
			default: begin
				err_n = 1'b1;
				ph_n  = scp_pkg::PH_ERROR;
			end
		endcase

		// step to the following entry
		if (do_next) begin
			epos_n   = epos_inc;
			bih_n    = 4'd0;
			gather_n = 24'd0;
			ph_n     = (epos_inc >= count_q) ? scp_pkg::PH_DONE : scp_pkg::PH_ENTRY_HDR;
		end

		// byte offset, with overflow making the file invalid
		if (!in_item.last) begin
			if (off_q == '1) begin
				err_n = 1'b1;
				ph_n  = scp_pkg::PH_ERROR;
			end else begin
				off_n = off_inc[OFFSET_BITS-1:0];
			end
		end
	end

	// result of the file that closes with this byte
	assign file_ok        = ~err_n & (ph_n == scp_pkg::PH_DONE);
	assign res_push       = fire & in_item.last;
	assign res_file_valid = file_ok;
	assign res_count      = file_ok ? count_q : '0;
	assign res_found      = file_ok & have_n;
	assign res_data       = (file_ok & have_n) ? kept_n : '0;

	// state registers, cleared again at the end of each file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= scp_pkg::PH_FILE_HDR;
			bih_q       <= 4'd0;
			gather_q    <= 24'd0;
			count_q     <= '0;
			epos_q      <= '0;
			code_left_q <= 32'd0;
			pad_q       <= 2'd0;
			off_q       <= '0;
			kept_q      <= '0;
			have_q      <= 1'b0;
			err_q       <= 1'b0;
		end else if (fire) begin
			if (in_item.last) begin
				ph_q        <= scp_pkg::PH_FILE_HDR;
				bih_q       <= 4'd0;
				gather_q    <= 24'd0;
				count_q     <= '0;
				epos_q      <= '0;
				code_left_q <= 32'd0;
				pad_q       <= 2'd0;
				off_q       <= '0;
				kept_q      <= '0;
				have_q      <= 1'b0;
				err_q       <= 1'b0;
			end else begin
				ph_q        <= ph_n;
				bih_q       <= bih_n;
				gather_q    <= gather_n;
				count_q     <= count_n;
				epos_q      <= epos_n;
				code_left_q <= code_left_n;
				pad_q       <= pad_n;
				off_q       <= off_n;
				kept_q      <= kept_n;
				have_q      <= have_n;
				err_q       <= err_n;
			end
		end
	end

endmodule

// ----- hdl/shader_container_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shader_container_parser_unit
// Streaming checker for an entry container file; reports validity, entry
// count and the fields of one selected entry.
// ----------------------------------------------------------------------------
// Use:
//   Input channel: present data_byte/last_byte with push; the item is taken
//   at an edge where push is high and full is low. last_byte marks the final
//   byte of a file. A front queue of two items takes the bytes.
//   Result channel: one result per file. While empty is low the result is on
//   the output ports; pop with empty low takes it. A two-item result queue
//   sits behind the parser.
//   Configuration: wr_en/wr_index/wr_data write magic, version and wanted
//   index, one register per write; write only while no file is in flight.
// Timing:
//   One byte per clock sustained; the parser handles one byte a cycle unless
//   a final byte waits on a full result queue. The result queue registers a
//   file's result as its final byte is taken; it shows if none is ahead of it.
// Reset and stall:
//   arst_n clears both queues and the parse state; registers go to their
//   reset values (wanted index = MAX_ENTRIES, count only). When pop is held
//   low and the result queue fills, the parser stops on the next final byte
//   and the front queue then raises full.
// ----------------------------------------------------------------------------
module shader_container_parser_unit #(
	parameter int unsigned MAX_ENTRIES = 4096,
	parameter int unsigned OFFSET_BITS = 32,
	parameter int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           wr_en,
	input  logic [scp_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [scp_pkg::REG_DATA_W-1:0] wr_data,
	// input items
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	// result items
	output logic                           empty,
	input  logic                           pop,
	output logic                           file_valid,
	output logic [CNT_W-1:0]               entry_count,
	output logic                           entry_found,
	output logic [31:0]                    found_inputs,
	output logic [31:0]                    found_outputs,
	output logic [15:0]                    found_samplers,
	output logic [15:0]                    found_extra,
	output logic [31:0]                    found_code_size,
	output logic [31:0]                    found_code_offset
);

	localparam int unsigned ITEM_W = $bits(scp_pkg::scp_item_t);
	localparam int unsigned RES_W  = 2 + CNT_W + $bits(scp_pkg::scp_found_t);

	scp_pkg::scp_hdr_cfg_t hdr_cfg_q;
	logic [CNT_W-1:0]      wanted_q;

	scp_pkg::scp_item_t    in_wr;
	scp_pkg::scp_item_t    in_rd;
	logic [ITEM_W-1:0]     in_rd_vec;
	logic                  in_empty;
	logic                  in_pop;

	logic                  res_push;
	logic                  res_full;
	logic                  res_file_valid;
	logic [CNT_W-1:0]      res_count;
	logic                  res_found;
	scp_pkg::scp_found_t   res_data;
	logic [RES_W-1:0]      res_wr_vec;
	logic [RES_W-1:0]      res_rd_vec;
	scp_pkg::scp_found_t   out_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cfg_q <= '0;
			wanted_q  <= CNT_W'(MAX_ENTRIES);
		end else if (wr_en) begin
			case (wr_index)
				scp_pkg::REG_MAGIC:   hdr_cfg_q.magic   <= wr_data;
				scp_pkg::REG_VERSION: hdr_cfg_q.version <= wr_data;
				scp_pkg::REG_WANTED:  wanted_q          <= wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// front queue
	assign in_wr.data = data_byte;
	assign in_wr.last = last_byte;

	scp_queue #(
		.WIDTH (ITEM_W)
	) u_in_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_wr),
		.full   (full),
		.pop    (in_pop),
		.rdata  (in_rd_vec),
		.empty  (in_empty)
	);

	assign in_rd = in_rd_vec;

	// parser
	scp_parser #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.OFFSET_BITS (OFFSET_BITS),
		.CNT_W       (CNT_W)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (~in_empty),
		.in_item        (in_rd),
		.in_pop         (in_pop),
		.hdr_cfg        (hdr_cfg_q),
		.wanted         (wanted_q),
		.res_full       (res_full),
		.res_push       (res_push),
		.res_file_valid (res_file_valid),
		.res_count      (res_count),
		.res_found      (res_found),
		.res_data       (res_data)
	);

	// result queue
	assign res_wr_vec = {res_file_valid, res_count, res_found, res_data};

	scp_queue #(
		.WIDTH (RES_W)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wr_vec),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rd_vec),
		.empty  (empty)
	);

	assign {file_valid, entry_count, entry_found, out_data} = res_rd_vec;
	assign found_inputs      = out_data.inputs;
	assign found_outputs     = out_data.outputs;
	assign found_samplers    = out_data.samplers;
	assign found_extra       = out_data.extra;
	assign found_code_size   = out_data.code_size;
	assign found_code_offset = out_data.code_offset;

endmodule

// ----- hdl/scp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks on the container parser, bound to the top level.
// ----------------------------------------------------------------------------
module scp_checker #(
	parameter int unsigned MAX_ENTRIES = 4096,
	parameter int unsigned CNT_W       = 13
) (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input logic             file_valid,
	input logic [CNT_W-1:0] entry_count,
	input logic             entry_found,
	input logic [31:0]      found_code_size,
	input logic [31:0]      found_code_offset
);

	// no result is shown while reset is held
	a_empty_in_reset: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// an entry is only reported for a valid file
	a_found_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && entry_found |-> file_valid)
		else $error("entry found in invalid file");

	// an invalid file carries a zero count, code size and code offset, and the count stays in range
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !file_valid |-> entry_count == '0 && found_code_size == 32'd0
		&& found_code_offset == 32'd0)
		else $error("invalid file with non-zero fields");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> entry_count <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above maximum");

	// a waiting result holds until taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(file_valid) && $stable(entry_count))
		else $error("waiting result changed");

endmodule

bind shader_container_parser_unit scp_checker #(
	.MAX_ENTRIES (MAX_ENTRIES),
	.CNT_W       (CNT_W)
) u_scp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.empty             (empty),
	.pop               (pop),
	.file_valid        (file_valid),
	.entry_count       (entry_count),
	.entry_found       (entry_found),
	.found_code_size   (found_code_size),
	.found_code_offset (found_code_offset)
);
